@@ design/dhcpfe_pkg.sv @@
package dhcpfe_pkg;

   // Configuration register indexes
   localparam logic [7:0] REG_V4_SERVER = 8'd0;
   localparam logic [7:0] REG_V4_CLIENT = 8'd1;
   localparam logic [7:0] REG_V6_CLIENT = 8'd2;
   localparam logic [7:0] REG_V6_SERVER = 8'd3;

   localparam logic [15:0] V4_SERVER_RESET = 16'd67;
   localparam logic [15:0] V4_CLIENT_RESET = 16'd68;
   localparam logic [15:0] V6_CLIENT_RESET = 16'd546;
   localparam logic [15:0] V6_SERVER_RESET = 16'd547;

   // Record kinds
   localparam logic [3:0] RK_V4_ADDR   = 4'd0;
   localparam logic [3:0] RK_XID       = 4'd1;
   localparam logic [3:0] RK_CI_YI     = 4'd2;
   localparam logic [3:0] RK_SI_GI     = 4'd3;
   localparam logic [3:0] RK_CHADDR    = 4'd4;
   localparam logic [3:0] RK_TRUNC     = 4'd5;
   localparam logic [3:0] RK_V6_ADDR   = 4'd6;
   localparam logic [3:0] RK_V6_HDR    = 4'd7;
   localparam logic [3:0] RK_OPT_START = 4'd8;
   localparam logic [3:0] RK_OPT_BYTE  = 4'd9;
   localparam logic [3:0] RK_OPT_END   = 4'd10;
   localparam logic [3:0] RK_FRAME_END = 4'd11;

   localparam logic [1:0] CLASS_NONE = 2'd0;
   localparam logic [1:0] CLASS_V4   = 2'd1;
   localparam logic [1:0] CLASS_V6   = 2'd2;

   localparam int MAX_RECS = 5;
   localparam int Q_DEPTH  = 4;

   typedef enum logic [3:0] {
      PH_ETH, PH_VLAN, PH_V4IP, PH_V4DHCP, PH_V4TAG, PH_V4LEN, PH_V6IP,
      PH_V6HDR, PH_V6OH0, PH_V6OH1, PH_V6OH2, PH_V6OH3, PH_DATA, PH_IDLE
   } phase_type;

   typedef struct packed {
      logic [7:0]  frame_byte;
      logic [11:0] frame_length;
      logic        last_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  record_kind;
      logic [63:0] record_value;
      logic [15:0] option_tag;
      logic [15:0] option_length;
      logic [15:0] item_index;
      logic        last_of_item;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [63:0] value;
      logic [15:0] tag;
      logic [15:0] len;
      logic [15:0] idx;
   } rec_type;

   // All records caused by one accepted byte
   typedef struct packed {
      logic [2:0]                  count;
      rec_type [MAX_RECS-1:0]      recs;
   } bundle_type;

   typedef struct packed {
      logic [15:0] v4_server;
      logic [15:0] v4_client;
      logic [15:0] v6_client;
      logic [15:0] v6_server;
   } port_cfg_type;

   function automatic rec_type make_rec(logic [3:0] kind, logic [63:0] value,
                                        logic [15:0] tag, logic [15:0] len,
                                        logic [15:0] idx);
      rec_type r;
      r.kind  = kind;
      r.value = value;
      r.tag   = tag;
      r.len   = len;
      r.idx   = idx;
      return r;
   endfunction

endpackage

@@ design/dhcpfe_front.sv @@
module dhcpfe_front #(
   parameter int MAX_FRAME = 2048
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  dhcpfe_pkg::req_type       req,
   input  dhcpfe_pkg::port_cfg_type  ports,
   output logic                      push,
   output dhcpfe_pkg::bundle_type    bundle
);

   localparam int POS_W = $clog2(MAX_FRAME + 1);
   localparam int CW    = (POS_W > 12 ? POS_W : 12) + 1;
   localparam logic [CW-1:0] MAXF = CW'(MAX_FRAME);

   logic [POS_W-1:0]      pos_ff, pos_in;
   dhcpfe_pkg::phase_type phase_ff, phase_in;
   logic [4:0]            net_ff, net_in;
   logic [5:0]            ihb_ff, ihb_in;
   logic [63:0]           pair_ff, pair_in;
   logic [63:0]           half_ff [4];
   logic [63:0]           half_in [4];
   logic [63:0]           shf_ff, shf_in;
   logic [7:0]            hlen_ff, hlen_in;
   logic [15:0]           tag_ff, tag_in;
   logic [15:0]           left_ff, left_in;
   logic [1:0]            class_ff, class_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= dhcpfe_pkg::PH_ETH;
         net_ff   <= 5'd14;
         ihb_ff   <= '0;
         pair_ff  <= '0;
         for (int i = 0; i < 4; i++) half_ff[i] <= '0;
         shf_ff   <= '0;
         hlen_ff  <= '0;
         tag_ff   <= '0;
         left_ff  <= '0;
         class_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         net_ff   <= net_in;
         ihb_ff   <= ihb_in;
         pair_ff  <= pair_in;
         for (int i = 0; i < 4; i++) half_ff[i] <= half_in[i];
         shf_ff   <= shf_in;
         hlen_ff  <= hlen_in;
         tag_ff   <= tag_in;
         left_ff  <= left_in;
         class_ff <= class_in;
      end
   end

   always_comb begin
      logic [7:0]    b;
      logic [CW-1:0] len_raw, len_c, pos_x, rel, d, room, lim;
      logic [63:0]   shf_new;
      logic [15:0]   sp, dp;
      logic [5:0]    ihb_v;
      logic [CW-1:0] rel_m8;
      logic [2:0]    nv;
      dhcpfe_pkg::phase_type after_opt;

      b       = req.frame_byte;
      len_raw = CW'(req.frame_length);
      len_c   = (len_raw > MAXF) ? MAXF : len_raw;
      pos_x   = CW'(pos_ff);
      rel     = pos_x - CW'(net_ff);
      shf_new = {shf_ff[55:0], b};
      sp      = shf_new[31:16];
      dp      = shf_new[15:0];
      room    = len_c - pos_x - CW'(1);
      rel_m8  = rel - CW'(8);
      ihb_v   = ihb_ff;
      d       = '0;
      lim     = '0;
      nv      = '0;
      after_opt = (class_ff == dhcpfe_pkg::CLASS_V4) ? dhcpfe_pkg::PH_V4TAG
                                                     : dhcpfe_pkg::PH_V6OH0;

      pos_in   = pos_ff;
      phase_in = phase_ff;
      net_in   = net_ff;
      ihb_in   = ihb_ff;
      pair_in  = pair_ff;
      for (int i = 0; i < 4; i++) half_in[i] = half_ff[i];
      shf_in   = shf_ff;
      hlen_in  = hlen_ff;
      tag_in   = tag_ff;
      left_in  = left_ff;
      class_in = class_ff;
      bundle   = '0;

      if (accept) begin
         if (pos_x < len_c) begin
            case (phase_ff)
               dhcpfe_pkg::PH_ETH, dhcpfe_pkg::PH_VLAN: begin
                  shf_in = shf_new;
                  if ((phase_ff == dhcpfe_pkg::PH_ETH && pos_x == CW'(13)) ||
                      (phase_ff == dhcpfe_pkg::PH_VLAN && pos_x == CW'(17))) begin
                     if (phase_ff == dhcpfe_pkg::PH_ETH && dp == 16'h8100 &&
                         len_c >= CW'(18)) begin
                        phase_in = dhcpfe_pkg::PH_VLAN;
                     end else begin
                        net_in = (phase_ff == dhcpfe_pkg::PH_ETH) ? 5'd14 : 5'd18;
                        if (dp == 16'h0800 && len_c >= CW'(net_in) + CW'(20))
                           phase_in = dhcpfe_pkg::PH_V4IP;
                        else if (dp == 16'h86DD && len_c >= CW'(net_in) + CW'(48))
                           phase_in = dhcpfe_pkg::PH_V6IP;
                        else
                           phase_in = dhcpfe_pkg::PH_IDLE;
                     end
                  end
               end
               dhcpfe_pkg::PH_V4IP: begin
                  if (rel == '0) begin
                     ihb_v  = {b[3:0], 2'b00};
                     ihb_in = ihb_v;
                     if (ihb_v < 6'd20 ||
                         len_c - CW'(net_ff) < CW'(ihb_v) + CW'(8))
                        phase_in = dhcpfe_pkg::PH_IDLE;
                  end else if (rel == CW'(9)) begin
                     if (b != 8'd17) phase_in = dhcpfe_pkg::PH_IDLE;
                  end else if (rel >= CW'(12) && rel <= CW'(19)) begin
                     pair_in = {pair_ff[55:0], b};
                  end
                  if (phase_in == dhcpfe_pkg::PH_V4IP && rel >= CW'(ihb_v) &&
                      rel <= CW'(ihb_v) + CW'(3)) begin
                     shf_in = shf_new;
                     if (rel == CW'(ihb_v) + CW'(3)) begin
                        if (sp == ports.v4_server || sp == ports.v4_client ||
                            dp == ports.v4_server || dp == ports.v4_client) begin
                           class_in = dhcpfe_pkg::CLASS_V4;
                           bundle.recs[nv] = dhcpfe_pkg::make_rec(
                              dhcpfe_pkg::RK_V4_ADDR, pair_ff, '0, '0, '0);
                           nv = nv + 3'd1;
                           if (len_c - CW'(net_ff) - CW'(ihb_v) - CW'(8) < CW'(240)) begin
                              bundle.recs[nv] = dhcpfe_pkg::make_rec(
                                 dhcpfe_pkg::RK_TRUNC, '0, '0, '0, '0);
                              nv = nv + 3'd1;
                              phase_in = dhcpfe_pkg::PH_IDLE;
                           end else begin
                              phase_in = dhcpfe_pkg::PH_V4DHCP;
                           end
                        end else begin
                           phase_in = dhcpfe_pkg::PH_IDLE;
                        end
                     end
                  end
               end
               dhcpfe_pkg::PH_V4DHCP: begin
                  d      = pos_x - (CW'(net_ff) + CW'(ihb_ff) + CW'(8));
                  shf_in = shf_new;
                  if (d == CW'(2)) begin
                     hlen_in = b;
                  end else if (d == CW'(11)) begin
                     bundle.recs[nv] = dhcpfe_pkg::make_rec(
                        dhcpfe_pkg::RK_XID, shf_new, '0, '0, '0);
                     nv = nv + 3'd1;
                  end else if (d == CW'(19)) begin
                     bundle.recs[nv] = dhcpfe_pkg::make_rec(
                        dhcpfe_pkg::RK_CI_YI, shf_new, '0, '0, '0);
                     nv = nv + 3'd1;
                  end else if (d == CW'(27)) begin
                     bundle.recs[nv] = dhcpfe_pkg::make_rec(
                        dhcpfe_pkg::RK_SI_GI, shf_new, '0, '0, '0);
                     nv = nv + 3'd1;
                  end
                  if (d >= CW'(28) && d < CW'(44)) begin
                     lim = (hlen_ff < 8'd16) ? CW'(hlen_ff) : CW'(16);
                     if (d - CW'(28) < lim) begin
                        bundle.recs[nv] = dhcpfe_pkg::make_rec(
                           dhcpfe_pkg::RK_CHADDR, 64'(b), '0, '0, 16'(d - CW'(28)));
                        nv = nv + 3'd1;
                     end
                  end
                  if (d >= CW'(239)) phase_in = dhcpfe_pkg::PH_V4TAG;
               end
               dhcpfe_pkg::PH_V4TAG: begin
                  if (len_c - pos_x <= CW'(1)) begin
                     phase_in = dhcpfe_pkg::PH_IDLE;
                  end else if (b == 8'd255) begin
                     bundle.recs[nv] = dhcpfe_pkg::make_rec(
                        dhcpfe_pkg::RK_OPT_END, '0, 16'd255, '0, '0);
                     nv = nv + 3'd1;
                     phase_in = dhcpfe_pkg::PH_IDLE;
                  end else if (b != 8'd0) begin
                     tag_in   = 16'(b);
                     phase_in = dhcpfe_pkg::PH_V4LEN;
                  end
               end
               dhcpfe_pkg::PH_V4LEN: begin
                  if (17'(b) > 17'(room)) begin
                     phase_in = dhcpfe_pkg::PH_IDLE;
                  end else begin
                     bundle.recs[nv] = dhcpfe_pkg::make_rec(
                        dhcpfe_pkg::RK_OPT_START, '0, tag_ff, 16'(b), '0);
                     nv = nv + 3'd1;
                     left_in  = 16'(b);
                     shf_in   = '0;
                     phase_in = (b != 8'd0) ? dhcpfe_pkg::PH_DATA : after_opt;
                  end
               end
               dhcpfe_pkg::PH_V6IP: begin
                  if (rel == CW'(6) && b != 8'd17) begin
                     phase_in = dhcpfe_pkg::PH_IDLE;
                  end else if (rel >= CW'(8) && rel <= CW'(39)) begin
                     half_in[rel_m8[4:3]] = {half_ff[rel_m8[4:3]][55:0], b};
                  end else if (rel >= CW'(40) && rel <= CW'(43)) begin
                     shf_in = shf_new;
                     if (rel == CW'(43)) begin
                        if (sp == ports.v6_client || sp == ports.v6_server ||
                            dp == ports.v6_client || dp == ports.v6_server) begin
                           class_in = dhcpfe_pkg::CLASS_V6;
                           for (int h = 0; h < 4; h++) begin
                              bundle.recs[h] = dhcpfe_pkg::make_rec(
                                 dhcpfe_pkg::RK_V6_ADDR, half_ff[h], '0, '0, 16'(h));
                           end
                           nv = 3'd4;
                           phase_in = (len_c - CW'(net_ff) - CW'(48) < CW'(4))
                                      ? dhcpfe_pkg::PH_IDLE : dhcpfe_pkg::PH_V6HDR;
                        end else begin
                           phase_in = dhcpfe_pkg::PH_IDLE;
                        end
                     end
                  end
               end
               dhcpfe_pkg::PH_V6HDR: begin
                  d      = pos_x - (CW'(net_ff) + CW'(48));
                  shf_in = shf_new;
                  if (d >= CW'(3)) begin
                     bundle.recs[nv] = dhcpfe_pkg::make_rec(
                        dhcpfe_pkg::RK_V6_HDR, {32'd0, shf_new[31:0]}, '0, '0, '0);
                     nv = nv + 3'd1;
                     phase_in = dhcpfe_pkg::PH_V6OH0;
                  end
               end
               dhcpfe_pkg::PH_V6OH0: begin
                  if (len_c - pos_x < CW'(4)) begin
                     phase_in = dhcpfe_pkg::PH_IDLE;
                  end else begin
                     shf_in   = 64'(b);
                     phase_in = dhcpfe_pkg::PH_V6OH1;
                  end
               end
               dhcpfe_pkg::PH_V6OH1: begin
                  shf_in   = shf_new;
                  phase_in = dhcpfe_pkg::PH_V6OH2;
               end
               dhcpfe_pkg::PH_V6OH2: begin
                  shf_in   = shf_new;
                  phase_in = dhcpfe_pkg::PH_V6OH3;
               end
               dhcpfe_pkg::PH_V6OH3: begin
                  shf_in = shf_new;
                  if (17'(dp) > 17'(room)) begin
                     phase_in = dhcpfe_pkg::PH_IDLE;
                  end else begin
                     bundle.recs[nv] = dhcpfe_pkg::make_rec(
                        dhcpfe_pkg::RK_OPT_START, '0, sp, dp, '0);
                     nv = nv + 3'd1;
                     tag_in   = sp;
                     left_in  = dp;
                     shf_in   = '0;
                     phase_in = (dp != 16'd0) ? dhcpfe_pkg::PH_DATA : after_opt;
                  end
               end
               dhcpfe_pkg::PH_DATA: begin
                  bundle.recs[nv] = dhcpfe_pkg::make_rec(
                     dhcpfe_pkg::RK_OPT_BYTE, 64'(b), tag_ff, '0, shf_ff[15:0]);
                  nv = nv + 3'd1;
                  shf_in  = shf_ff + 64'd1;
                  left_in = left_ff - 16'd1;
                  if (left_ff == 16'd1) phase_in = after_opt;
               end
               default: begin
               end
            endcase
         end

         if (pos_ff < POS_W'(MAX_FRAME)) pos_in = pos_ff + POS_W'(1);

         if (req.last_byte) begin
            // class as updated by this byte, so a match on the last byte counts
            bundle.recs[nv] = dhcpfe_pkg::make_rec(
               dhcpfe_pkg::RK_FRAME_END, 64'(class_in), '0, '0, '0);
            nv = nv + 3'd1;
            pos_in   = '0;
            phase_in = dhcpfe_pkg::PH_ETH;
            net_in   = 5'd14;
            ihb_in   = '0;
            pair_in  = '0;
            for (int i = 0; i < 4; i++) half_in[i] = '0;
            shf_in   = '0;
            hlen_in  = '0;
            tag_in   = '0;
            left_in  = '0;
            class_in = '0;
         end
      end

      bundle.count = nv;
   end

   assign push = accept && (bundle.count != 3'd0);

endmodule

@@ design/dhcpfe_queue.sv @@
module dhcpfe_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  dhcpfe_pkg::bundle_type wdata,
   input  logic                   pop,
   output dhcpfe_pkg::bundle_type head,
   output logic                   not_empty,
   output logic                   full
);

   localparam int PW = $clog2(dhcpfe_pkg::Q_DEPTH);

   dhcpfe_pkg::bundle_type mem_ff [dhcpfe_pkg::Q_DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [PW:0]   cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_comb begin
      wr_in  = push ? wr_ff + PW'(1) : wr_ff;
      rd_in  = pop ? rd_ff + PW'(1) : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   assign head      = mem_ff[rd_ff];
   assign not_empty = (cnt_ff != '0);
   assign full      = (cnt_ff == (PW+1)'(dhcpfe_pkg::Q_DEPTH));

endmodule

@@ design/dhcpfe_back.sv @@
module dhcpfe_back (
   input  logic                   clock,
   input  logic                   reset,
   input  dhcpfe_pkg::bundle_type head,
   input  logic                   head_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output dhcpfe_pkg::rsp_type    rsp_data,
   output logic                   pop
);

   logic [2:0] sel_ff, sel_in;
   logic       last;
   dhcpfe_pkg::rec_type cur;

   assign cur  = head.recs[sel_ff];
   assign last = (sel_ff == head.count - 3'd1);

   assign rsp_valid              = head_valid;
   assign rsp_data.record_kind   = cur.kind;
   assign rsp_data.record_value  = cur.value;
   assign rsp_data.option_tag    = cur.tag;
   assign rsp_data.option_length = cur.len;
   assign rsp_data.item_index    = cur.idx;
   assign rsp_data.last_of_item  = last;

   assign pop = head_valid && !rsp_stall && last;

   always_comb begin
      sel_in = sel_ff;
      if (head_valid && !rsp_stall) sel_in = last ? 3'd0 : sel_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= '0;
      end else begin
         sel_ff <= sel_in;
      end
   end

endmodule

@@ design/dhcp_frame_field_extractor.sv @@
// DHCP frame field extractor: one frame byte per transaction, records out.
// Each byte's records are registered in the bundle queue before they leave.
// Throughput: one byte per cycle in while the queue is not full; one record per
//   cycle out while rsp_stall is low. A 4-entry queue absorbs bytes with many records.
// Reset: synchronous, active high; parser returns to the Ethernet header
//   phase, the queue empties and the port registers take their defaults.
module dhcp_frame_field_extractor #(
   parameter int MAX_FRAME = 2048
) (
   input  logic                clock,
   input  logic                reset,
   // byte input channel
   input  logic                req_valid,
   output logic                req_stall,
   input  dhcpfe_pkg::req_type req_data,
   // record output channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output dhcpfe_pkg::rsp_type rsp_data,
   // register write port
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [7:0]          csr_index,
   input  logic [15:0]         csr_wdata
);

   dhcpfe_pkg::port_cfg_type ports_ff, ports_in;
   dhcpfe_pkg::bundle_type   bundle, head;
   logic accept, push, pop, not_empty, full;

   // Port registers; writes must land only while idle: the user's duty, not enforced here.
   assign csr_ready = 1'b1;

   always_comb begin
      ports_in = ports_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            dhcpfe_pkg::REG_V4_SERVER: ports_in.v4_server = csr_wdata;
            dhcpfe_pkg::REG_V4_CLIENT: ports_in.v4_client = csr_wdata;
            dhcpfe_pkg::REG_V6_CLIENT: ports_in.v6_client = csr_wdata;
            dhcpfe_pkg::REG_V6_SERVER: ports_in.v6_server = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ports_ff.v4_server <= dhcpfe_pkg::V4_SERVER_RESET;
         ports_ff.v4_client <= dhcpfe_pkg::V4_CLIENT_RESET;
         ports_ff.v6_client <= dhcpfe_pkg::V6_CLIENT_RESET;
         ports_ff.v6_server <= dhcpfe_pkg::V6_SERVER_RESET;
      end else begin
         ports_ff <= ports_in;
      end
   end

   // Front end: byte parser, builds all records of one byte in a cycle.
   // Stall only when the queue is full.
   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   dhcpfe_front #(.MAX_FRAME(MAX_FRAME)) u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .ports  (ports_ff),
      .push   (push),
      .bundle (bundle)
   );

   // Record bundles wait here between parser and serializer.
   dhcpfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wdata     (bundle),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .full      (full)
   );

   // Back end: emits the head bundle one record per transaction.
   dhcpfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (not_empty),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .pop        (pop)
   );

   // A full queue always has something to send.
   a_full_has_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("queue full with no output pending");

   // Frame end is always the final record of its byte.
   a_frame_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.record_kind == dhcpfe_pkg::RK_FRAME_END)
         |-> rsp_data.last_of_item)
      else $error("frame end record not last of its byte");

   // Nothing is pending right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule
